// ===== rtl/core/h2r_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// h2r_pkg
// shared types and constants of the hsv to rgb222 converter
// ----------------------------------------------------------------------------
package h2r_pkg;

    typedef logic [2:0] t_sector;

    // configuration register indexes
    localparam logic [1:0] CFG_SATURATION  = 2'd0;
    localparam logic [1:0] CFG_VALUE_LEVEL = 2'd1;

    localparam logic [7:0] FULL_SCALE = 8'd255;

    // three whole turns of 1440 quarter-degrees lift any 13-bit hue above zero
    localparam logic [13:0] HUE_LIFT    = 14'd4320;
    localparam logic [7:0]  SECTOR_SPAN = 8'd240;

    // reciprocals: 2185/2^15 ~ 1/15 (floor), 43/2^8 ~ 1/6, 4369/2^16 ~ 1/15 (with +1)
    localparam logic [14:0] RECIP15_A = 15'd2185;
    localparam logic [7:0]  RECIP6    = 8'd43;
    localparam logic [12:0] RECIP15_B = 13'd4369;

    localparam t_sector SEC_RED_UP      = 3'd0;
    localparam t_sector SEC_RED_DOWN    = 3'd1;
    localparam t_sector SEC_GREEN_UP    = 3'd2;
    localparam t_sector SEC_GREEN_DOWN  = 3'd3;
    localparam t_sector SEC_BLUE_UP     = 3'd4;
    localparam t_sector SEC_BLUE_DOWN   = 3'd5;

endpackage
`default_nettype wire

// ===== rtl/core/h2r_hue_split.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// h2r_hue_split
// two-stage hue wrap: splits a signed quarter-degree hue into a 60-degree
// sector and the offset within that sector
// ----------------------------------------------------------------------------
module h2r_hue_split (
    input  wire                    i_clk,
    input  wire                    i_ce,
    input  wire  [12:0]            i_hue,
    output h2r_pkg::t_sector       o_sector,
    output logic [7:0]             o_offset
);
    import h2r_pkg::*;

    logic [13:0] w_lifted;
    logic [24:0] w_q_prod;
    logic [13:0] r_lifted;
    logic [5:0]  r_quot;
    logic [13:0] w_rem;
    logic [13:0] w_q6_prod;
    logic [2:0]  w_q6;
    logic [5:0]  w_sec_full;
    t_sector     r_sector;
    logic [7:0]  r_offset;

    // stage 1: lift into positive range, quotient by 240 as (u >> 4) / 15
    assign w_lifted = 14'($signed({i_hue[12], i_hue}) + $signed(HUE_LIFT));
    assign w_q_prod = 25'(w_lifted[13:4]) * 25'(RECIP15_A);

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_lifted <= w_lifted;
            r_quot   <= w_q_prod[20:15];
        end
    end

    // stage 2: remainder within the sector, sector is quotient mod 6
    assign w_rem      = 14'(r_lifted - 14'(r_quot) * 14'(SECTOR_SPAN));
    assign w_q6_prod  = 14'(r_quot) * 14'(RECIP6);
    assign w_q6       = w_q6_prod[10:8];
    assign w_sec_full = 6'(r_quot - 6'(w_q6) * 6'd6);

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_offset <= w_rem[7:0];
            r_sector <= w_sec_full[2:0];
        end
    end

    assign o_sector = r_sector;
    assign o_offset = r_offset;

endmodule
`default_nettype wire

// ===== rtl/core/hsv_to_rgb222_converter.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsv_to_rgb222_converter
// hue stream in, rgb222 pixel stream out, saturation and value from registers
// ----------------------------------------------------------------------------
// Takes one hue per clock and returns one RGB222 pixel per hue through a
// five-stage pipeline (hue wrap, sector split and chroma, ramp product,
// ramp scale, channel mix and pack). The whole pipeline advances together:
// it moves whenever the output register is empty or being taken, so a stall
// on the output holds every stage in place and also holds off the input.
// Saturation and value must be written through the configuration port only
// while no pixel is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module hsv_to_rgb222_converter (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // configuration
    input  wire         i_cfg_we,
    input  wire  [1:0]  i_cfg_addr,
    input  wire  [7:0]  i_cfg_data,
    // hue stream
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [15:0] s_axis_tdata,   // [12:0] hue_quarter_deg, [15:13] zero
    // pixel stream
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [7:0]  m_axis_tdata    // [7:0] packed_colour
);
    import h2r_pkg::*;

    logic        w_ce;
    logic [7:0]  r_saturation;
    logic [7:0]  r_value;

    logic        r_vld1, r_vld2, r_vld3, r_vld4, r_vld5;

    logic [15:0] r_vs;
    t_sector     w_sector;
    logic [7:0]  w_offset;
    logic [16:0] w_c_sum;
    logic [7:0]  r_c2;

    logic [7:0]  w_ramp_arg;
    logic [15:0] r_ramp_p;
    logic [7:0]  r_c3, r_m3;
    t_sector     r_sec3;

    logic [25:0] w_x_prod;
    logic [7:0]  r_x4, r_c4, r_m4;
    t_sector     r_sec4;

    logic [7:0]  w_r, w_g, w_b;
    logic [7:0]  w_r_out, w_g_out, w_b_out;
    logic [7:0]  r_tdata;

    assign w_ce          = !r_vld5 || m_axis_tready;
    assign s_axis_tready = w_ce;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_saturation <= FULL_SCALE;
            r_value      <= FULL_SCALE;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_SATURATION:  r_saturation <= i_cfg_data;
                CFG_VALUE_LEVEL: r_value      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
            r_vld4 <= 1'b0;
            r_vld5 <= 1'b0;
        end else if (w_ce) begin
            r_vld1 <= s_axis_tvalid;
            r_vld2 <= r_vld1;
            r_vld3 <= r_vld2;
            r_vld4 <= r_vld3;
            r_vld5 <= r_vld4;
        end
    end

    // stages 1 and 2 of the hue path
    h2r_hue_split u_hue_split (
        .i_clk    (i_clk),
        .i_ce     (w_ce),
        .i_hue    (s_axis_tdata[12:0]),
        .o_sector (w_sector),
        .o_offset (w_offset)
    );

    // stage 1: v*s
    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_vs <= 16'(r_value) * 16'(r_saturation);
        end
    end

    // stage 2: c = v*s/255, exact for every product of two 8-bit levels
    assign w_c_sum = 17'(r_vs) + 17'd1 + 17'(r_vs[15:8]);

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_c2 <= w_c_sum[15:8];
        end
    end

    // stage 3: ramp numerator, rising on even sectors, falling on odd
    assign w_ramp_arg = w_sector[0] ? 8'(SECTOR_SPAN - w_offset) : w_offset;

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_ramp_p <= 16'(r_c2) * 16'(w_ramp_arg);
            r_m3     <= 8'(r_value - r_c2);
            r_c3     <= r_c2;
            r_sec3   <= w_sector;
        end
    end

    // stage 4: x = p/240 as ((p >> 4) + 1) * 4369 >> 16
    assign w_x_prod = 26'(13'(r_ramp_p[15:4]) + 13'd1) * 26'(RECIP15_B);

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_x4   <= w_x_prod[23:16];
            r_c4   <= r_c3;
            r_m4   <= r_m3;
            r_sec4 <= r_sec3;
        end
    end

    // stage 5: channel mix by sector, add offset, pack top bits
    always_comb begin
        case (r_sec4)
            SEC_RED_UP:     begin w_r = r_c4; w_g = r_x4; w_b = 8'd0; end
            SEC_RED_DOWN:   begin w_r = r_x4; w_g = r_c4; w_b = 8'd0; end
            SEC_GREEN_UP:   begin w_r = 8'd0; w_g = r_c4; w_b = r_x4; end
            SEC_GREEN_DOWN: begin w_r = 8'd0; w_g = r_x4; w_b = r_c4; end
            SEC_BLUE_UP:    begin w_r = r_x4; w_g = 8'd0; w_b = r_c4; end
            default:        begin w_r = r_c4; w_g = 8'd0; w_b = r_x4; end
        endcase
    end

    assign w_r_out = 8'(w_r + r_m4);
    assign w_g_out = 8'(w_g + r_m4);
    assign w_b_out = 8'(w_b + r_m4);

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_tdata <= {w_r_out[7:6], w_g_out[7:6], w_b_out[7:6], 2'b00};
        end
    end

    assign m_axis_tvalid = r_vld5;
    assign m_axis_tdata  = r_tdata;

endmodule
`default_nettype wire

// ===== rtl/core/h2r_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// h2r_checker
// port-level checks of the hsv to rgb222 converter, bound to the top level
// ----------------------------------------------------------------------------
module h2r_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        s_axis_tvalid,
    input wire        s_axis_tready,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [7:0]  m_axis_tdata
);

    // a held pixel request keeps its data
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("pixel request dropped or changed while stalled");

    // low two bits of the pixel are always zero
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[1:0] == 2'b00)
        else $error("pixel padding bits not zero");

    // an empty output never holds off the input
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

    // the pipeline comes out of reset empty
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("pixel request right after reset");

endmodule

bind hsv_to_rgb222_converter h2r_checker u_h2r_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the hsv to rgb222 converter
// ----------------------------------------------------------------------------
// Sends signed quarter-degree hues through the slave stream and checks
// every pixel on the master stream against a local integer model of the
// conversion. Saturation and value are changed between phases, only while
// the pipeline is empty. The phases run with free flow, with sender gaps,
// with receiver stalls and with both at once.
// ----------------------------------------------------------------------------
module tb_top;
    import h2r_pkg::*;

    localparam int HUE_TURN    = 1440;
    localparam int NUM_PHASES  = 8;
    localparam int PHASE_HUES  = 150;
    localparam int LATENCY_PAD = 12;
    localparam int MAX_REPORTS = 10;

    // indexes past the last register, writes there must change nothing
    localparam logic [1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [1:0] CFG_SPARE_3 = 2'd3;

    typedef enum int {
        FLOW_FREE,
        FLOW_SEND_IDLE,
        FLOW_RECV_STALL,
        FLOW_BOTH
    } flow_mode_t;

    typedef struct {
        logic [12:0] hue;
        logic [7:0]  colour;
    } pixel_expect_t;

    class colour_scoreboard;
        logic [7:0]    sat_level;
        logic [7:0]    val_level;
        pixel_expect_t pixel_q[$];
        int            errors;
        int            hues_seen;
        int            pixels_checked;

        function new();
            sat_level      = FULL_SCALE;
            val_level      = FULL_SCALE;
            errors         = 0;
            hues_seen      = 0;
            pixels_checked = 0;
        endfunction

        function void note_config(logic [1:0] idx, logic [7:0] data);
            if (idx == CFG_SATURATION) begin
                sat_level = data;
            end else if (idx == CFG_VALUE_LEVEL) begin
                val_level = data;
            end
        endfunction

        function logic [7:0] predict_colour(logic [12:0] hue);
            int      h;
            int      f;
            int      c;
            int      x;
            int      m;
            int      r;
            int      g;
            int      b;
            int      span;
            t_sector sector;
            span = int'(SECTOR_SPAN);
            h = int'($signed(hue)) % HUE_TURN;
            if (h < 0) begin
                h += HUE_TURN;
            end
            sector = t_sector'(h / span);
            f = h % span;
            c = (int'(val_level) * int'(sat_level)) / int'(FULL_SCALE);
            m = int'(val_level) - c;
            if (sector[0] == 1'b0) begin
                x = (c * f) / span;
            end else begin
                x = (c * (span - f)) / span;
            end
            case (sector)
                SEC_RED_UP: begin
                    r = c; g = x; b = 0;
                end
                SEC_RED_DOWN: begin
                    r = x; g = c; b = 0;
                end
                SEC_GREEN_UP: begin
                    r = 0; g = c; b = x;
                end
                SEC_GREEN_DOWN: begin
                    r = 0; g = x; b = c;
                end
                SEC_BLUE_UP: begin
                    r = x; g = 0; b = c;
                end
                default: begin
                    r = c; g = 0; b = x;
                end
            endcase
            r = (r + m) & 8'hFF;
            g = (g + m) & 8'hFF;
            b = (b + m) & 8'hFF;
            return 8'(((r >> 6) << 6) | ((g >> 6) << 4) | ((b >> 6) << 2));
        endfunction

        function void note_hue(logic [12:0] hue);
            pixel_expect_t e;
            e.hue    = hue;
            e.colour = predict_colour(hue);
            pixel_q.push_back(e);
            hues_seen++;
        endfunction

        function void check_colour(logic [7:0] got);
            pixel_expect_t e;
            if (pixel_q.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS) begin
                    $display("pixel with no pending hue: got %02h", got);
                end
                return;
            end
            e = pixel_q.pop_front();
            pixels_checked++;
            if (got !== e.colour) begin
                errors++;
                if (errors <= MAX_REPORTS) begin
                    $display("pixel mismatch: hue %0d sat %0d val %0d expected %02h got %02h",
                             $signed(e.hue), sat_level, val_level, e.colour, got);
                end
            end
        endfunction

        function int pending();
            return pixel_q.size();
        endfunction
    endclass

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic [1:0]  i_cfg_addr    = '0;
    logic [7:0]  i_cfg_data    = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = '0;   // [12:0] hue_quarter_deg, [15:13] zero
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;         // [7:0] packed_colour

    colour_scoreboard sb = new();
    flow_mode_t       flow = FLOW_FREE;

    hsv_to_rgb222_converter u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    function automatic int idle_pct(bit recv_side);
        case (flow)
            FLOW_SEND_IDLE:  return recv_side ? 0 : 87;
            FLOW_RECV_STALL: return recv_side ? 87 : 0;
            FLOW_BOTH:       return 18;
            default:         return 0;
        endcase
    endfunction

    task automatic send_hue(input logic [12:0] hue);
        int pct;
        pct = idle_pct(1'b0);
        if ($urandom_range(99) < pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, hue};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_hue(hue);
    endtask

    task automatic set_levels(input logic [7:0] sat, input logic [7:0] val, input bit stray);
        logic [7:0] junk;
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= CFG_SATURATION;
        i_cfg_data <= sat;
        sb.note_config(CFG_SATURATION, sat);
        @(posedge i_clk);
        i_cfg_addr <= CFG_VALUE_LEVEL;
        i_cfg_data <= val;
        sb.note_config(CFG_VALUE_LEVEL, val);
        @(posedge i_clk);
        if (stray) begin
            junk = 8'($urandom);
            i_cfg_addr <= CFG_SPARE_2;
            i_cfg_data <= junk;
            sb.note_config(CFG_SPARE_2, junk);
            @(posedge i_clk);
            junk = 8'($urandom);
            i_cfg_addr <= CFG_SPARE_3;
            i_cfg_data <= junk;
            sb.note_config(CFG_SPARE_3, junk);
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // stop sending, let every pixel come out and the pipeline settle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() > 0) @(posedge i_clk);
        repeat (LATENCY_PAD) @(posedge i_clk);
    endtask

    // pixel side: check every accepted pixel, then pick the next ready
    initial begin
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
                sb.check_colour(m_axis_tdata);
            end
            m_axis_tready <= ($urandom_range(99) >= idle_pct(1'b1));
        end
    end

    initial begin
        logic [12:0] directed_hues[$];
        logic [7:0]  sat;
        logic [7:0]  val;
        int          pick;
        int          hv;

        // sector edges, wrap points both ways and the 13-bit extremes
        directed_hues = '{13'd0, 13'd239, 13'd240, 13'd480, 13'd720, 13'd960,
                          13'd1200, 13'd1439, 13'd1440, 13'(-1), 13'(-1440),
                          13'd2879, 13'h1000, 13'h0FFF, 13'd120, 13'd360,
                          13'd600, 13'd840, 13'd1080, 13'd1320, 13'h1FFF};

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset levels are full saturation and full value
        flow = FLOW_FREE;
        foreach (directed_hues[i]) begin
            send_hue(directed_hues[i]);
        end
        drain();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: begin sat = 8'd0;   val = 8'd255; end
                1: begin sat = 8'd255; val = 8'd0;   end
                2: begin sat = 8'd0;   val = 8'd0;   end
                3: begin sat = 8'd255; val = 8'd255; end
                4: begin sat = 8'd1;   val = 8'd254; end
                default: begin
                    sat = 8'($urandom_range(255));
                    val = 8'($urandom_range(255));
                end
            endcase
            set_levels(sat, val, ph == 3 || ph == 6);
            flow = flow_mode_t'(ph % 4);
            repeat (PHASE_HUES) begin
                pick = $urandom_range(99);
                if (pick < 60) begin
                    hv = $urandom_range(8191);
                end else if (pick < 85) begin
                    hv = $urandom_range(4319) - HUE_TURN;
                end else begin
                    // just around a sector boundary, from one turn below zero to two turns above
                    hv = (int'($urandom_range(18)) - 6) * int'(SECTOR_SPAN)
                         + int'($urandom_range(2)) - 1;
                end
                send_hue(13'(hv));
            end
            drain();
        end

        $display("%0d hues sent, %0d pixels checked, %0d errors",
                 sb.hues_seen, sb.pixels_checked, sb.errors);
        $display("levels covered zero, full scale and random values under four flow patterns");
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("timeout with %0d pixels outstanding", sb.pending());
        $display("tb_top NOT OK");
        $finish;
    end

endmodule
